>>> rtl/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
// Needs i_clk and i_rst_n in the scope that expands them.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_CONJ  = 3'd4,
        CMD_SCALE = 3'd5,
        CMD_EQ    = 3'd6,
        CMD_POLAR = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic               is_equal;
        logic [1:0]         status;
    } t_out_word;

    // atan(2^-i) in Q30 radians
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

>>> rtl/complex_arith_unit.sv
// Complex arithmetic unit top level: fully pipelined fixed-point complex ALU.
// Depends on cau_pkg and complex_arith_unit_macros.svh.
`timescale 1ns / 1ps

// Fixed-point complex ALU. Each input word carries an opcode and two complex
// operands in signed fixed point with FRAC_BITS fraction bits; the working
// width is DATA_WIDTH capped at 32 bits (W), taken from the low bits of each
// 32-bit field and sign extended back into the 32-bit result fields. Opcodes:
// add, subtract, multiply, divide, conjugate, scale by b_real, equality test,
// and polar conversion (floor of the exact magnitude, atan2 phase in radians
// by CORDIC vectoring over CORDIC_STEPS iterations). Overflowing parts clamp
// and report status 1; division by zero returns zero with status 2.
// The unit accepts one word every cycle while not stalled. It has three front
// stages (operand register, six parallel W x W multipliers, product sums), one
// divider setup stage, NIT = max(W + FRAC_BITS, CORDIC_STEPS) iteration stages
// and the output register. The iteration length is set by the restoring
// divider, which retires one quotient bit per stage, unless CORDIC_STEPS is
// larger; the square root (W steps) and the CORDIC run alongside in the same
// stages. The whole pipeline holds while a finished word waits at the output,
// so nothing is lost or repeated under backpressure.
module complex_arith_unit #(
    parameter int DATA_WIDTH   = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cau_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cau_pkg::t_out_word o_out_data
);
    import cau_pkg::*;

`include "complex_arith_unit_macros.svh"

    localparam int W    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int W2   = 2 * W;
    localparam int DQ   = W + FRAC_BITS;
    localparam int NIT  = (DQ > CORDIC_STEPS) ? DQ : CORDIC_STEPS;
    localparam int XW   = W + 3;
    localparam int ZW   = 34;
    localparam int SW   = ((W2 > DQ) ? W2 : DQ) + 2;
    localparam int SH   = 30 - FRAC_BITS;
    localparam int SH_R = (SH > 0) ? SH - 1 : 0;

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
    localparam logic signed [ZW-1:0] Z_RND  = ZW'(1) << SH_R;

    typedef struct packed {
        logic signed [W-1:0] rr;
        logic signed [W-1:0] ri;
        logic                sat;
        logic                eq;
    } t_pre;

    typedef struct packed {
        logic signed [XW-1:0] cx;
        logic signed [XW-1:0] cy;
        logic signed [ZW-1:0] cz;
    } t_cor;

    typedef struct packed {
        logic [W2-1:0] rem;
        logic [DQ-1:0] dq;
        logic          neg;
        logic          ovf;
    } t_part;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [W-1:0] ar;
        logic signed [W-1:0] ai;
        logic signed [W-1:0] br;
        logic signed [W-1:0] bi;
    } t_s0;

    typedef struct packed {
        logic [2:0]           cmd;
        logic signed [W2-1:0] p0;
        logic signed [W2-1:0] p1;
        logic signed [W2-1:0] p2;
        logic signed [W2-1:0] p3;
        logic signed [W2-1:0] p4;
        logic signed [W2-1:0] p5;
        t_pre                 pre;
        t_cor                 cor;
        logic                 czero;
    } t_s1;

    typedef struct packed {
        logic [2:0]    cmd;
        t_pre          pre;
        logic [W2-1:0] sq;
        logic [W2-1:0] nr;
        logic          nr_neg;
        logic [W2-1:0] ni;
        logic          ni_neg;
        t_cor          cor;
        logic          czero;
    } t_s2;

    typedef struct packed {
        logic [2:0]    cmd;
        t_pre          pre;
        logic [W2-1:0] den;
        logic          den_zero;
        t_part         dr;
        t_part         di;
        logic [W2-1:0] sv;
        logic [W2-1:0] sres;
        t_cor          cor;
        logic          czero;
    } t_it;

    // Clamp a wide signed value to W bits; MSB of the result flags a clamp.
    function automatic logic [W:0] f_sat(input logic signed [SW-1:0] v);
        if (v > SAT_HI) begin
            return {1'b1, SAT_HI[W-1:0]};
        end else if (v < SAT_LO) begin
            return {1'b1, SAT_LO[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    // One restoring division step: bring in the next dividend bit.
    function automatic t_part f_div_step(input t_part p, input logic [W2-1:0] den);
        logic [W2:0] t;
        t_part       o;
        o = p;
        t = {p.rem, p.dq[DQ-1]};
        if (t >= {1'b0, den}) begin
            o.rem = W2'(t - {1'b0, den});
            o.dq  = {p.dq[DQ-2:0], 1'b1};
        end else begin
            o.rem = t[W2-1:0];
            o.dq  = {p.dq[DQ-2:0], 1'b0};
        end
        return o;
    endfunction

    // Signed quotient with clamping.
    function automatic logic [W:0] f_div_fin(input t_part p);
        logic signed [SW-1:0] q;
        q = $signed(SW'(p.dq));
        if (p.ovf) begin
            return {1'b1, p.neg ? SAT_LO[W-1:0] : SAT_HI[W-1:0]};
        end
        if (p.neg) begin
            q = -q;
        end
        return f_sat(q);
    endfunction

    // One digit of the bitwise integer square root; returns {rest, root}.
    function automatic logic [2*W2-1:0] f_sqrt_step(input logic [W2-1:0] sv,
                                                    input logic [W2-1:0] sres,
                                                    input int k);
        logic [W2-1:0] b;
        logic [W2:0]   t;
        b = W2'(1) << (W2 - 2 - 2 * k);
        t = {1'b0, sres} + {1'b0, b};
        if ({1'b0, sv} >= t) begin
            return {W2'(sv - t[W2-1:0]), W2'((sres >> 1) + b)};
        end
        return {sv, W2'(sres >> 1)};
    endfunction

    // One CORDIC vectoring rotation.
    function automatic t_cor f_cordic(input t_cor c, input int k);
        t_cor                 o;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] ang;
        xs  = $signed(c.cx) >>> k;
        ys  = $signed(c.cy) >>> k;
        ang = $signed(ZW'(ATAN_Q30[5'(k)]));
        if (c.cy >= 0) begin
            o.cx = c.cx + ys;
            o.cy = c.cy - xs;
            o.cz = c.cz + ang;
        end else begin
            o.cx = c.cx - ys;
            o.cy = c.cy + xs;
            o.cz = c.cz - ang;
        end
        return o;
    endfunction

    logic      w_adv;
    logic      r_v0, r_v1, r_v2;
    logic [NIT:0] r_itv;
    logic      r_out_valid;
    t_s0       r_s0, n_s0;
    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_it       r_it [0:NIT];
    t_it       n_it_in;
    t_it       n_it [1:NIT];
    t_out_word r_out, n_out;
    logic [2:0] r_out_cmd;

    // Advance every stage unless the output word is held by the sink.
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Stage 0: take the working width of each operand.
    always_comb begin
        n_s0.cmd = i_in_data.cmd;
        n_s0.ar  = i_in_data.a_real[W-1:0];
        n_s0.ai  = i_in_data.a_imag[W-1:0];
        n_s0.br  = i_in_data.b_real[W-1:0];
        n_s0.bi  = i_in_data.b_imag[W-1:0];
    end

    // Stage 1: products, simple ops, CORDIC quadrant fold.
    always_comb begin
        logic [W:0] w_a;
        logic [W:0] w_b;
        w_a = '0;
        w_b = '0;
        n_s1.cmd = r_s0.cmd;
        n_s1.p0  = W2'($signed(r_s0.ar)) * W2'($signed(r_s0.br));
        n_s1.p1  = W2'($signed(r_s0.ai)) * W2'($signed(r_s0.bi));
        n_s1.p2  = W2'($signed(r_s0.ar)) * W2'($signed(r_s0.bi));
        n_s1.p3  = W2'($signed(r_s0.ai)) * W2'($signed(r_s0.br));
        // squares feed the divisor or the magnitude
        if (r_s0.cmd == CMD_POLAR) begin
            n_s1.p4 = W2'($signed(r_s0.ar)) * W2'($signed(r_s0.ar));
            n_s1.p5 = W2'($signed(r_s0.ai)) * W2'($signed(r_s0.ai));
        end else begin
            n_s1.p4 = W2'($signed(r_s0.br)) * W2'($signed(r_s0.br));
            n_s1.p5 = W2'($signed(r_s0.bi)) * W2'($signed(r_s0.bi));
        end
        n_s1.pre.eq = 1'b0;
        case (r_s0.cmd)
            CMD_ADD: begin
                w_a = f_sat(SW'($signed(r_s0.ar)) + SW'($signed(r_s0.br)));
                w_b = f_sat(SW'($signed(r_s0.ai)) + SW'($signed(r_s0.bi)));
            end
            CMD_SUB: begin
                w_a = f_sat(SW'($signed(r_s0.ar)) - SW'($signed(r_s0.br)));
                w_b = f_sat(SW'($signed(r_s0.ai)) - SW'($signed(r_s0.bi)));
            end
            CMD_CONJ: begin
                w_a = {1'b0, r_s0.ar};
                w_b = f_sat(-SW'($signed(r_s0.ai)));
            end
            CMD_EQ: begin
                n_s1.pre.eq = (r_s0.ar == r_s0.br) && (r_s0.ai == r_s0.bi);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
        n_s1.pre.rr  = w_a[W-1:0];
        n_s1.pre.ri  = w_b[W-1:0];
        n_s1.pre.sat = w_a[W] | w_b[W];
        // fold the left half plane onto the right half
        n_s1.czero  = (r_s0.ar == '0) && (r_s0.ai == '0);
        n_s1.cor.cx = XW'($signed(r_s0.ar));
        n_s1.cor.cy = XW'($signed(r_s0.ai));
        n_s1.cor.cz = '0;
        if (r_s0.ar < 0) begin
            if (r_s0.ai >= 0) begin
                n_s1.cor.cx = XW'($signed(r_s0.ai));
                n_s1.cor.cy = -XW'($signed(r_s0.ar));
                n_s1.cor.cz = $signed(ZW'({ATAN_Q30[0], 1'b0}));
            end else begin
                n_s1.cor.cx = -XW'($signed(r_s0.ai));
                n_s1.cor.cy = XW'($signed(r_s0.ar));
                n_s1.cor.cz = -$signed(ZW'({ATAN_Q30[0], 1'b0}));
            end
        end
    end

    // Stage 2: product sums, multiply and scale results, dividend magnitudes.
    always_comb begin
        logic signed [SW-1:0] w_mr;
        logic signed [SW-1:0] w_mi;
        logic signed [SW-1:0] w_nr;
        logic signed [SW-1:0] w_ni;
        logic [W:0]           w_a;
        logic [W:0]           w_b;
        w_mr = SW'($signed(r_s1.p0)) - SW'($signed(r_s1.p1));
        w_mi = SW'($signed(r_s1.p2)) + SW'($signed(r_s1.p3));
        w_nr = SW'($signed(r_s1.p0)) + SW'($signed(r_s1.p1));
        w_ni = SW'($signed(r_s1.p3)) - SW'($signed(r_s1.p2));
        w_a  = '0;
        w_b  = '0;
        n_s2.cmd   = r_s1.cmd;
        n_s2.pre   = r_s1.pre;
        n_s2.cor   = r_s1.cor;
        n_s2.czero = r_s1.czero;
        case (r_s1.cmd)
            CMD_MUL: begin
                w_a = f_sat(w_mr >>> FRAC_BITS);
                w_b = f_sat(w_mi >>> FRAC_BITS);
                n_s2.pre.rr  = w_a[W-1:0];
                n_s2.pre.ri  = w_b[W-1:0];
                n_s2.pre.sat = w_a[W] | w_b[W];
            end
            CMD_SCALE: begin
                w_a = f_sat(SW'($signed(r_s1.p0)) >>> FRAC_BITS);
                w_b = f_sat(SW'($signed(r_s1.p3)) >>> FRAC_BITS);
                n_s2.pre.rr  = w_a[W-1:0];
                n_s2.pre.ri  = w_b[W-1:0];
                n_s2.pre.sat = w_a[W] | w_b[W];
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
        n_s2.sq     = W2'($unsigned(r_s1.p4)) + W2'($unsigned(r_s1.p5));
        n_s2.nr_neg = w_nr < 0;
        n_s2.nr     = W2'(n_s2.nr_neg ? -w_nr : w_nr);
        n_s2.ni_neg = w_ni < 0;
        n_s2.ni     = W2'(n_s2.ni_neg ? -w_ni : w_ni);
    end

    // Stage 3: divider setup and overflow check, square root setup.
    always_comb begin
        n_it_in.cmd      = r_s2.cmd;
        n_it_in.pre      = r_s2.pre;
        n_it_in.den      = r_s2.sq;
        n_it_in.den_zero = (r_s2.sq == '0);
        n_it_in.dr.neg   = r_s2.nr_neg;
        n_it_in.dr.ovf   = W2'(r_s2.nr[W2-1:W]) >= r_s2.sq;
        n_it_in.dr.rem   = W2'(r_s2.nr[W2-1:W]);
        n_it_in.dr.dq    = {r_s2.nr[W-1:0], {FRAC_BITS{1'b0}}};
        n_it_in.di.neg   = r_s2.ni_neg;
        n_it_in.di.ovf   = W2'(r_s2.ni[W2-1:W]) >= r_s2.sq;
        n_it_in.di.rem   = W2'(r_s2.ni[W2-1:W]);
        n_it_in.di.dq    = {r_s2.ni[W-1:0], {FRAC_BITS{1'b0}}};
        n_it_in.sv       = r_s2.sq;
        n_it_in.sres     = '0;
        n_it_in.cor      = r_s2.cor;
        n_it_in.czero    = r_s2.czero;
    end

    // Iteration stages: divider bit, root digit and CORDIC rotation per stage.
    always_comb begin
        logic [2*W2-1:0] w_sq;
        for (int k = 0; k < NIT; k++) begin
            w_sq = '0;
            n_it[k+1] = r_it[k];
            if (k < DQ) begin
                n_it[k+1].dr = f_div_step(r_it[k].dr, r_it[k].den);
                n_it[k+1].di = f_div_step(r_it[k].di, r_it[k].den);
            end
            if (k < W) begin
                w_sq = f_sqrt_step(r_it[k].sv, r_it[k].sres, k);
                n_it[k+1].sv   = w_sq[2*W2-1:W2];
                n_it[k+1].sres = w_sq[W2-1:0];
            end
            if (k < CORDIC_STEPS) begin
                n_it[k+1].cor = f_cordic(r_it[k].cor, k);
            end
        end
    end

    // Output stage: pick the result by opcode, round the phase, clamp.
    always_comb begin
        logic [W:0]           w_a;
        logic [W:0]           w_b;
        logic signed [ZW-1:0] w_z;
        w_z = r_it[NIT].cor.cz;
        if (SH > 0) begin
            w_z = (r_it[NIT].cor.cz + Z_RND) >>> SH;
        end
        n_out.is_equal = 1'b0;
        case (r_it[NIT].cmd)
            CMD_DIV: begin
                w_a = f_div_fin(r_it[NIT].dr);
                w_b = f_div_fin(r_it[NIT].di);
                if (r_it[NIT].den_zero) begin
                    n_out.status = ST_DIV0;
                    w_a = '0;
                    w_b = '0;
                end else begin
                    n_out.status = (w_a[W] | w_b[W]) ? ST_SAT : ST_OK;
                end
            end
            CMD_POLAR: begin
                w_a = f_sat($signed(SW'(r_it[NIT].sres)));
                w_b = r_it[NIT].czero ? '0 : f_sat(SW'(w_z));
                n_out.status = (w_a[W] | w_b[W]) ? ST_SAT : ST_OK;
            end
            default: begin
                w_a = {1'b0, r_it[NIT].pre.rr};
                w_b = {1'b0, r_it[NIT].pre.ri};
                n_out.is_equal = r_it[NIT].pre.eq;
                n_out.status   = r_it[NIT].pre.sat ? ST_SAT : ST_OK;
            end
        endcase
        n_out.res_real = 32'($signed(w_a[W-1:0]));
        n_out.res_imag = 32'($signed(w_b[W-1:0]));
    end

    // Valid bits travel with the words; drop nothing while held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_itv       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v0        <= i_in_valid;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            r_itv       <= {r_itv[NIT-1:0], r_v2};
            r_out_valid <= r_itv[NIT];
        end
    end

    // Payload registers: advance with the pipeline, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0      <= n_s0;
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_it[0]   <= n_it_in;
            for (int k = 1; k <= NIT; k++) begin
                r_it[k] <= n_it[k];
            end
            r_out     <= n_out;
            r_out_cmd <= r_it[NIT].cmd;
        end
    end

    `CAU_ASSERT_NOW(a_div0_only_div, o_out_valid && (o_out_data.status == ST_DIV0), r_out_cmd == CMD_DIV, "divide-by-zero status on a non-divide word")
    `CAU_ASSERT_NOW(a_div0_zero, o_out_valid && (o_out_data.status == ST_DIV0), (o_out_data.res_real == '0) && (o_out_data.res_imag == '0), "divide by zero with nonzero result")
    `CAU_ASSERT_NOW(a_eq_only_eq, o_out_valid && o_out_data.is_equal, r_out_cmd == CMD_EQ, "is_equal set on a non-equals word")
    `CAU_ASSERT_NEXT(a_hold_stages, !w_adv, $stable(r_itv) && $stable(r_v2), "pipeline moved while stalled")

endmodule

>>> test/tb_complex_arith_unit.sv
// Self-checking testbench for the complex arithmetic unit.
// Depends on cau_pkg and the complex_arith_unit top level.
`timescale 1ns / 1ps

module tb_complex_arith_unit;
    import cau_pkg::*;

    localparam int  FRAC        = 16;
    localparam int  STEPS       = 16;
    localparam int  LATENCY     = 53;
    localparam int  RAND_WORDS  = 900;
    localparam int  HOLD_CYCLES = 300;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_data;

    t_out_word result_q[$];
    t_row      dir_rows[$];
    int        mismatches   = 0;
    int        words_sent   = 0;
    int        words_seen   = 0;
    int        cycles       = 0;
    int        send_idle    = 0;
    int        recv_idle    = 0;
    bit        hold_request = 1'b0;

    complex_arith_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clamp to the signed 32-bit range, flag saturation.
    function automatic longint clamp32(longint v, inout logic [1:0] st);
        if (v > longint'(MAXV)) begin
            st = ST_SAT;
            return longint'(MAXV);
        end
        if (v < longint'(MINV)) begin
            st = ST_SAT;
            return longint'(MINV);
        end
        return v;
    endfunction

    // floor((p1 + p2) / 2^FRAC) without overflowing the 64-bit sum.
    function automatic longint shifted_sum(longint p1, longint p2);
        longint h;
        h = (p1 >>> 1) + (p2 >>> 1) + longint'(p1 & p2 & 64'd1);
        return h >>> (FRAC - 1);
    endfunction

    // Exact p1 + p2 as sign and magnitude; 2^63 stays positive.
    function automatic logic [63:0] sum_magnitude(longint p1, longint p2, output bit neg);
        logic [63:0] s;
        s   = 64'(p1) + 64'(p2);
        neg = 1'b0;
        if (s == 64'h8000_0000_0000_0000) return s;
        if (s[63]) begin
            neg = 1'b1;
            return 64'd0 - s;
        end
        return s;
    endfunction

    function automatic longint quotient_part(logic [63:0] n, bit neg, logic [63:0] den,
                                             inout logic [1:0] st);
        logic [63:0] q;
        logic [63:0] rem;
        bit          carry;
        bit          qb;
        q   = n / den;
        rem = n % den;
        if (q[63:32] != 0) begin
            st = ST_SAT;
            return neg ? longint'(MINV) : longint'(MAXV);
        end
        for (int i = 0; i < FRAC; i++) begin
            carry = rem[63];
            qb    = 1'b0;
            rem   = rem << 1;
            if (carry || rem >= den) begin
                rem = rem - den;
                qb  = 1'b1;
            end
            q = (q << 1) | 64'(qb);
        end
        return clamp32(neg ? -longint'(q) : longint'(q), st);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bm;
        root = 0;
        bm   = 64'd1 << 62;
        while (bm > v) bm = bm >> 2;
        while (bm != 0) begin
            if (v >= root + bm) begin
                v    = v - (root + bm);
                root = (root >> 1) + bm;
            end else begin
                root = root >> 1;
            end
            bm = bm >> 2;
        end
        return root;
    endfunction

    // CORDIC vectoring phase in Q30, rounded half up to Q16.
    function automatic longint cordic_phase(longint x, longint y);
        longint z;
        longint t;
        longint xs;
        longint ys;
        longint a0;
        z  = 0;
        a0 = longint'(ATAN_Q30[0]);
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 2 * a0;
            end else begin
                t = x; x = -y; y = t; z = -2 * a0;
            end
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
            end
        end
        return (z + (longint'(1) << (30 - FRAC - 1))) >>> (30 - FRAC);
    endfunction

    function automatic t_out_word compute_result(t_in_word w);
        t_out_word   r;
        longint      ar, ai, br, bi, rr, ri;
        logic [1:0]  st;
        bit          nr, ni;
        logic [63:0] mr, mi, den;
        ar = longint'(w.a_real);
        ai = longint'(w.a_imag);
        br = longint'(w.b_real);
        bi = longint'(w.b_imag);
        rr = 0;
        ri = 0;
        st = ST_OK;
        r  = '0;
        case (t_cmd'(w.cmd))
            CMD_ADD: begin
                rr = clamp32(ar + br, st);
                ri = clamp32(ai + bi, st);
            end
            CMD_SUB: begin
                rr = clamp32(ar - br, st);
                ri = clamp32(ai - bi, st);
            end
            CMD_MUL: begin
                rr = clamp32(shifted_sum(ar * br, -(ai * bi)), st);
                ri = clamp32(shifted_sum(ar * bi, ai * br), st);
            end
            CMD_DIV: begin
                den = 64'(br * br) + 64'(bi * bi);
                if (den == 0) begin
                    st = ST_DIV0;
                end else begin
                    mr = sum_magnitude(ar * br, ai * bi, nr);
                    mi = sum_magnitude(ai * br, -(ar * bi), ni);
                    rr = quotient_part(mr, nr, den, st);
                    ri = quotient_part(mi, ni, den, st);
                end
            end
            CMD_CONJ: begin
                rr = ar;
                ri = clamp32(-ai, st);
            end
            CMD_SCALE: begin
                rr = clamp32((ar * br) >>> FRAC, st);
                ri = clamp32((ai * br) >>> FRAC, st);
            end
            CMD_EQ: r.is_equal = (ar == br && ai == bi);
            default: begin
                mr = floor_sqrt(64'(ar * ar) + 64'(ai * ai));
                rr = clamp32(longint'(mr), st);
                ri = clamp32(cordic_phase(ar, ai), st);
            end
        endcase
        r.res_real = rr[31:0];
        r.res_imag = ri[31:0];
        r.status   = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 5))
                    0: return MAXV;
                    1: return MINV;
                    2: return 32'd0;
                    3: return ONE;
                    4: return -ONE;
                    default: return 32'hFFFFFFFF;
                endcase
            end
            1, 2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH word %0d %s: got %0d expected %0d", words_seen, field, got, want);
        mismatches++;
    endtask

    function automatic t_in_word mk(t_cmd c, logic [31:0] ar, logic [31:0] ai,
                                   logic [31:0] br, logic [31:0] bi);
        t_in_word w;
        w.cmd    = c;
        w.a_real = ar;
        w.a_imag = ai;
        w.b_real = br;
        w.b_imag = bi;
        return w;
    endfunction

    task automatic add_row(t_in_word w, bit typed = 0, logic [31:0] rr = 0, logic [31:0] ri = 0,
                           logic eq = 0, logic [1:0] st = ST_OK);
        t_row row;
        row.word   = w;
        row.typed  = typed;
        row.result = '{res_real: rr, res_imag: ri, is_equal: eq, status: st};
        dir_rows.push_back(row);
    endtask

    // Offer one word and hold it until the handshake; queue its expectation.
    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        result_q.push_back(typed ? want : compute_result(w));
        words_sent++;
        // Drop valid for a random gap, keep it high otherwise.
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int  held;
        bit  hold_done;
        held      = 0;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                i_out_ready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES) hold_done = 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // Check every accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word want;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected word", o_out_data.res_real, 0);
            end else begin
                want = result_q.pop_front();
                if (o_out_data.res_real !== want.res_real)
                    report_mismatch("res_real", o_out_data.res_real, want.res_real);
                if (o_out_data.res_imag !== want.res_imag)
                    report_mismatch("res_imag", o_out_data.res_imag, want.res_imag);
                if (o_out_data.is_equal !== want.is_equal)
                    report_mismatch("is_equal", o_out_data.is_equal, want.is_equal);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
            end
            words_seen++;
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_in_word w;
        int       tail;

        // Directed words: expected results typed in where obvious.
        add_row(mk(CMD_ADD, 0, 0, 0, 0), 1, 0, 0, 0, ST_OK);
        add_row(mk(CMD_ADD, MAXV, 0, MAXV, 0), 1, MAXV, 0, 0, ST_SAT);
        add_row(mk(CMD_SUB, MINV, 0, 1, 0), 1, MINV, 0, 0, ST_SAT);
        add_row(mk(CMD_MUL, ONE, 0, ONE, 0), 1, ONE, 0, 0, ST_OK);
        add_row(mk(CMD_DIV, ONE, ONE, 0, 0), 1, 0, 0, 0, ST_DIV0);
        add_row(mk(CMD_CONJ, 5, MINV, 0, 0), 1, 5, MAXV, 0, ST_SAT);
        add_row(mk(CMD_EQ, MINV, MAXV, MINV, MAXV), 1, 0, 0, 1, ST_OK);
        add_row(mk(CMD_EQ, 1, 2, 1, 3), 1, 0, 0, 0, ST_OK);
        add_row(mk(CMD_POLAR, 0, 0, MAXV, MAXV), 1, 0, 0, 0, ST_OK);
        add_row(mk(CMD_SCALE, 3, -7, ONE, 0), 1, 3, -7, 0, ST_OK);
        add_row(mk(CMD_ADD, MINV, MINV, MINV, MINV));
        add_row(mk(CMD_SUB, 32'h12345678, -5, -32'h1234, MINV));
        add_row(mk(CMD_MUL, MINV, MINV, MINV, MINV));
        add_row(mk(CMD_MUL, MAXV, MINV, MAXV, MAXV));
        add_row(mk(CMD_DIV, ONE, 0, ONE, 0));
        add_row(mk(CMD_DIV, MINV, MAXV, 1, 0));
        add_row(mk(CMD_DIV, MAXV, MINV, MINV, MAXV));
        add_row(mk(CMD_CONJ, MAXV, 0, 0, 0));
        add_row(mk(CMD_SCALE, MINV, MAXV, MINV, 0));
        add_row(mk(CMD_POLAR, ONE, 0, 0, 0));
        add_row(mk(CMD_POLAR, -ONE, ONE, 0, 0));
        add_row(mk(CMD_POLAR, -ONE, -ONE, 0, 0));
        add_row(mk(CMD_POLAR, MINV, MINV, 0, 0));
        add_row(mk(CMD_POLAR, MAXV, MAXV, 0, 0));
        add_row(mk(CMD_POLAR, 0, MINV, 0, 0));

        // Hold reset at the start, once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 32;
        recv_idle = 51;
        foreach (dir_rows[k]) send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].result);

        for (int n = 0; n < RAND_WORDS; n++) begin
            // Swap the idle mix, then run without idling.
            if (n == RAND_WORDS / 3) begin
                send_idle = 51;
                recv_idle = 32;
            end
            if (n == 2 * RAND_WORDS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            // Long receiver hold-off while words keep coming.
            if (n == 100) hold_request = 1'b1;
            // Pause the sender until the pipeline drains.
            if (n == 450) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (result_q.size() != 0) @(posedge i_clk);
            end
            w.cmd    = 3'($urandom_range(0, 7));
            w.a_real = pick_operand();
            w.a_imag = pick_operand();
            w.b_real = pick_operand();
            w.b_imag = pick_operand();
            // Make equality hits common enough to matter.
            if (t_cmd'(w.cmd) == CMD_EQ && $urandom_range(0, 1)) begin
                w.b_real = w.a_real;
                if ($urandom_range(0, 2) != 0) w.b_imag = w.a_imag;
            end
            send_word(w, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // Drain, then allow the pipeline latency for stray words.
        while (result_q.size() != 0) @(posedge i_clk);
        tail = 0;
        while (tail < 2 * LATENCY) begin
            @(posedge i_clk);
            tail++;
        end

        $display("Covered %0d words over all eight opcodes, %0d results checked,", words_sent,
                 words_seen);
        $display("with saturation, divide by zero, CORDIC quadrants and backpressure stalls.");
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
